// File: src/pidc_pkg.sv
// shared constants, register indexes and saturation helper for the pid controller
// no dependencies; imported by pidc_div and pid_controller_clamped_integral
`default_nettype none

package pidc_pkg;

    localparam int FRAC_BITS = 16;                 // fraction bits of every fixed point value
    localparam int DATA_W    = 32;                 // width of data words
    localparam int MUL_W     = DATA_W + 1;         // multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;          // full product width
    localparam int SUM_W     = 60;                 // wide accumulator for the drive sum
    localparam int DIV_W     = 64;                 // dividend and quotient width
    localparam int DIV_BITS  = 2;                  // quotient bits retired per cycle
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 3;
    localparam int DERIV_EXP = 56;                 // derivative term limited to +/- 2^56

    localparam logic [DIV_W-1:0] DERIV_LIMIT = DIV_W'(1) << DERIV_EXP;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_SETPOINT       = 3'd4
    } cfg_reg_t;

    // clip a wide signed value to the 32 bit signed range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic fits;
        begin
            fits = (&x[PROD_W-1:DATA_W-1]) || ~(|x[PROD_W-1:DATA_W-1]);
            if (fits)
            begin
                sat32 = x[DATA_W-1:0];
            end
            else if (x[PROD_W-1])
            begin
                sat32 = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                sat32 = {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: src/pidc_div.sv
// unsigned radix-4 restoring divider, two quotient bits per cycle
// depends on pidc_pkg for widths
`default_nettype none

module pidc_div
    import pidc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIV_W-1:0]  dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DIV_W-1:0]       quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    // two dependent restoring steps
    logic [DATA_W:0]   trial_a, trial_b;
    logic              ge_a, ge_b;
    logic [DATA_W-1:0] rem_a, rem_b;
    logic [DIV_W-1:0]  quo_a, quo_b;

    always_comb
    begin
        trial_a = {rem_reg, quo_reg[DIV_W-1]};
        ge_a    = trial_a >= {1'b0, dvs_reg};
        rem_a   = ge_a ? DATA_W'(trial_a - {1'b0, dvs_reg}) : trial_a[DATA_W-1:0];
        quo_a   = {quo_reg[DIV_W-2:0], ge_a};

        trial_b = {rem_a, quo_a[DIV_W-1]};
        ge_b    = trial_b >= {1'b0, dvs_reg};
        rem_b   = ge_b ? DATA_W'(trial_b - {1'b0, dvs_reg}) : trial_b[DATA_W-1:0];
        quo_b   = {quo_a[DIV_W-2:0], ge_b};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = rem_b;
            quo_next = quo_b;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/pid_controller_clamped_integral.sv
// positional pid controller with integral clamp and variable time step
// depends on pidc_pkg and pidc_div
//
// usage:
//   input channel (in_valid / in_stall) carries one word: command, sample and
//   time_step. command 0 takes sample as a measurement (error = setpoint - sample),
//   command 1 takes sample as a ready error. in_stall is high while a word is in work.
//   output channel (out_valid / out_stall) returns one word per input word:
//   drive, saturated and bad_time. a finished word sits in the output register,
//   so the next input word is taken while it waits to be read.
//   config channel (cfg_valid / cfg_ready) writes gain_p, gain_i, gain_d,
//   integral_limit and setpoint by index; cfg_ready is always high. write only when idle.
// timing:
//   one shared 33x33 multiplier runs four products in turn, then the derivative
//   quotient comes out of a radix-4 serial divider. in_stall falls in the same cycle
//   that out_valid rises, so the next word can be taken while out_valid is high.
//   a zero time step skips the divider.
// reset clears gains, limit, setpoint, the integral and the previous error.
// if the output word is still stalled when the next one finishes, the sequencer
// holds in its last step until the output register frees.
`default_nettype none

module pid_controller_clamped_integral
    import pidc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 command,
    input  wire logic signed [31:0]   sample,
    input  wire logic        [31:0]   time_step,
    // output channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [31:0]        drive,
    output logic                      saturated,
    output logic                      bad_time,
    // config channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'b00000000000001,
        ST_MUL_I    = 14'b00000000000010,
        ST_TERM_I   = 14'b00000000000100,
        ST_MUL_T    = 14'b00000000001000,
        ST_INTEG    = 14'b00000000010000,
        ST_CLAMP    = 14'b00000000100000,
        ST_MUL_P    = 14'b00000001000000,
        ST_PROP     = 14'b00000010000000,
        ST_MUL_D    = 14'b00000100000000,
        ST_DIV_GO   = 14'b00001000000000,
        ST_DIV_WAIT = 14'b00010000000000,
        ST_DERIV    = 14'b00100000000000,
        ST_TOTAL    = 14'b01000000000000,
        ST_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [DATA_W-1:0] gain_p_reg, gain_p_next;
    logic signed [DATA_W-1:0] gain_i_reg, gain_i_next;
    logic signed [DATA_W-1:0] gain_d_reg, gain_d_next;
    logic        [DATA_W-2:0] limit_reg, limit_next;
    logic signed [DATA_W-1:0] setpoint_reg, setpoint_next;

    // controller state
    logic signed [DATA_W-1:0] integ_reg, integ_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;

    // per word working registers
    logic signed [DATA_W-1:0] err_reg, err_next;
    logic        [DATA_W-1:0] dt_reg, dt_next;
    logic                     bad_reg, bad_next;
    logic signed [DATA_W:0]   diff_reg, diff_next;
    logic signed [DATA_W-1:0] t_reg, t_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [SUM_W-1:0]  deriv_reg, deriv_next;
    logic                     neg_reg, neg_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] drive_reg, drive_next;
    logic                     sat_reg, sat_next;
    logic                     bad_out_reg, bad_out_next;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // divider hookup
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quotient;

    // helpers
    logic                     in_take;
    logic                     out_free;
    logic signed [DATA_W:0]   err_wide;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [DATA_W-1:0] t2_val;
    logic signed [DATA_W:0]   integ_sum;
    logic signed [DATA_W:0]   t_wide;
    logic signed [DATA_W:0]   lim_wide;
    logic signed [PROD_W-1:0] prod_mag;
    logic        [DIV_W-1:0]  deriv_mag;
    logic signed [PROD_W-1:0] sum_wide;
    logic signed [DATA_W-1:0] drive_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign err_wide  = {setpoint_reg[DATA_W-1], setpoint_reg} - {sample[DATA_W-1], sample};
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign t2_val    = sat32(prod_sh);
    assign integ_sum = {integ_reg[DATA_W-1], integ_reg} + {t2_val[DATA_W-1], t2_val};
    assign t_wide    = {t_reg[DATA_W-1], t_reg};
    assign lim_wide  = {2'b00, limit_reg};
    assign prod_mag  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign deriv_mag = (div_quotient > DERIV_LIMIT) ? DERIV_LIMIT : div_quotient;
    assign sum_wide  = {{(PROD_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
    assign drive_sat = sat32(sum_wide);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = {err_reg[DATA_W-1], err_reg};
        mul_b = {gain_i_reg[DATA_W-1], gain_i_reg};
        case (state_reg)
            ST_MUL_T:
            begin
                mul_a = {t_reg[DATA_W-1], t_reg};
                mul_b = {1'b0, dt_reg};
            end
            ST_MUL_P:
            begin
                mul_b = {gain_p_reg[DATA_W-1], gain_p_reg};
            end
            ST_MUL_D:
            begin
                mul_a = diff_reg;
                mul_b = {gain_d_reg[DATA_W-1], gain_d_reg};
            end
            default:
            begin
                mul_a = {err_reg[DATA_W-1], err_reg};
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        limit_next     = limit_reg;
        setpoint_next  = setpoint_reg;
        integ_next     = integ_reg;
        prev_next      = prev_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        bad_next       = bad_reg;
        diff_next      = diff_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        deriv_next     = deriv_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        drive_next     = drive_reg;
        sat_next       = sat_reg;
        bad_out_next   = bad_out_reg;
        div_start      = 1'b0;
        div_dividend   = prod_mag[DIV_W-1:0];

        // register writes, unknown indexes fall through
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN_P:         gain_p_next   = cfg_data;
                REG_GAIN_I:         gain_i_next   = cfg_data;
                REG_GAIN_D:         gain_d_next   = cfg_data;
                REG_INTEGRAL_LIMIT: limit_next    = cfg_data[DATA_W-2:0];
                REG_SETPOINT:       setpoint_next = cfg_data;
                default:            limit_next    = limit_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    // measurement error is saturated to 32 bits
                    err_next   = command ? sample
                               : sat32({{(PROD_W-DATA_W-1){err_wide[DATA_W]}}, err_wide});
                    dt_next    = time_step;
                    bad_next   = (time_step == '0);
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I:
            begin
                prod_next  = mul_p;
                diff_next  = {err_reg[DATA_W-1], err_reg} - {prev_reg[DATA_W-1], prev_reg};
                state_next = ST_TERM_I;
            end
            ST_TERM_I:
            begin
                t_next     = t2_val;
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                // zero time step gives a zero product, so the integral holds
                prod_next  = mul_p;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                t_next     = sat32({{(PROD_W-DATA_W-1){integ_sum[DATA_W]}}, integ_sum});
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                integ_next = t_reg;
                if (limit_reg != '0)
                begin
                    if (t_wide > lim_wide)
                    begin
                        integ_next = lim_wide[DATA_W-1:0];
                    end
                    else if (t_wide < -lim_wide)
                    begin
                        integ_next = DATA_W'(-lim_wide);
                    end
                end
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                prod_next  = mul_p;
                state_next = ST_PROP;
            end
            ST_PROP:
            begin
                sum_next   = prod_sh[SUM_W-1:0]
                           + {{(SUM_W-DATA_W){integ_reg[DATA_W-1]}}, integ_reg};
                state_next = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                prod_next  = mul_p;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                if (bad_reg)
                begin
                    deriv_next = '0;
                    state_next = ST_TOTAL;
                end
                else
                begin
                    // divide magnitudes, restore the sign for truncation toward zero
                    neg_next   = prod_reg[PROD_W-1];
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DERIV;
                end
            end
            ST_DERIV:
            begin
                deriv_next = neg_reg ? -deriv_mag[SUM_W-1:0] : deriv_mag[SUM_W-1:0];
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                sum_next   = sum_reg + deriv_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = drive_sat;
                    sat_next       = ({{(SUM_W-DATA_W){drive_sat[DATA_W-1]}}, drive_sat}
                                      != sum_reg);
                    bad_out_next   = bad_reg;
                    prev_next      = err_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            limit_reg     <= '0;
            setpoint_reg  <= '0;
            integ_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            limit_reg     <= limit_next;
            setpoint_reg  <= setpoint_next;
            integ_reg     <= integ_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        err_reg     <= err_next;
        dt_reg      <= dt_next;
        bad_reg     <= bad_next;
        diff_reg    <= diff_next;
        t_reg       <= t_next;
        prod_reg    <= prod_next;
        sum_reg     <= sum_next;
        deriv_reg   <= deriv_next;
        neg_reg     <= neg_next;
        drive_reg   <= drive_next;
        sat_reg     <= sat_next;
        bad_out_reg <= bad_out_next;
    end

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;
    assign bad_time  = bad_out_reg;

`ifndef SYNTHESIS
    // a new output word only comes from the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && out_valid_next |=> $past(state_reg == ST_DONE))
        else $error("output loaded outside the final step");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done while not waiting");

    // after the clamp step the integral is within the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_P && limit_reg != '0) |->
            ($signed({integ_reg[DATA_W-1], integ_reg}) <= lim_wide &&
             $signed({integ_reg[DATA_W-1], integ_reg}) >= -lim_wide))
        else $error("integral outside clamp");

    // zero time step drops the derivative term
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TOTAL && bad_reg) |-> deriv_reg == '0)
        else $error("derivative used with zero time step");
`endif

endmodule

`default_nettype wire
